### design/gha_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Shared widths, operation and status codes, and the pipeline item types.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Pool geometry, fixed by the handle field widths.
  localparam int unsigned SLOTS = 256;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned GEN_W = 8;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned ST_W  = 3;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_LOOKUP  = 2'd2,
    FUNC_RSVD    = 2'd3
  } func_e;

  // Result status codes carried in the output tuser.
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_STALE     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // What the pipeline does with an accepted item.
  typedef enum logic [2:0] {
    ACT_ERR,
    ACT_ALLOC_FRESH,
    ACT_ALLOC_QUEUE,
    ACT_RELEASE,
    ACT_LOOKUP
  } act_e;

  // Payload of one item in flight.
  typedef struct packed {
    act_e             act;
    logic [IDX_W-1:0] slot;
    logic [GEN_W-1:0] gen;
    status_e          status;
  } item_t;

  // Write request into the generation table.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] addr;
    logic [GEN_W-1:0] gen;
  } gen_wr_t;

endpackage

### design/gha_gen_table.sv
// ----------------------------------------------------------------------------
// Generation table
// One generation per slot in a memory with a registered read, per-slot valid
// flags that make unwritten slots read as zero, and forwarding of the write
// made at the same edge as the read.
// ----------------------------------------------------------------------------
module gha_gen_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        clear_i,
  input  logic [gha_pkg::IDX_W-1:0]   rd_addr_i,
  input  gha_pkg::gen_wr_t            wr_i,
  output logic [gha_pkg::GEN_W-1:0]   cur_gen_o
);

  logic [gha_pkg::GEN_W-1:0] mem [gha_pkg::SLOTS];
  logic [gha_pkg::SLOTS-1:0] vld_q;

  logic [gha_pkg::GEN_W-1:0] rd_q;
  logic [gha_pkg::IDX_W-1:0] rd_addr_q;
  logic                      rd_vld_q;
  logic [gha_pkg::IDX_W-1:0] fwd_addr_q;
  logic [gha_pkg::GEN_W-1:0] fwd_gen_q;
  logic                      fwd_vld_q;

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      mem[wr_i.addr] <= wr_i.gen;
    end
    if (en_i) begin
      rd_q       <= mem[rd_addr_i];
      rd_addr_q  <= rd_addr_i;
      fwd_addr_q <= wr_i.addr;
      fwd_gen_q  <= wr_i.gen;
    end
  end

  // Valid flags and control side of the read and forwarding registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (wr_i.valid) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (en_i) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        fwd_vld_q <= wr_i.valid;
      end
    end
  end

  // A write at the read edge is not in the read data, so take it from the
  // forwarding register; a never-written slot reads as zero.
  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == rd_addr_q)) begin
      cur_gen_o = fwd_gen_q;
    end else if (rd_vld_q) begin
      cur_gen_o = rd_q;
    end else begin
      cur_gen_o = '0;
    end
  end

endmodule

### design/generational_handle_allocator_top.sv
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out (slot, generation) handles, fresh slots first and then from a FIFO
// free list, bumps a slot's generation on release and checks handles on lookup.
// ----------------------------------------------------------------------------
// An accepted item passes through the s1, s2 and output registers to the output.
// Throughput: one item per cycle; the queue bookkeeping is settled at the
// accept edge, and the generation table read-modify-write is forwarded.
// Input is held off only while a finished result waits on the output.
// Reset and a register write clear the queue, the fresh counter and all
// generations at once; there is no clearing pass.
module generational_handle_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: active_slots
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] slot_index, [15:8] generation
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_index, [15:8] out_generation
  output logic [2:0]  m_axis_tuser    // [2:0] status
);

  localparam logic [gha_pkg::CNT_W-1:0] SlotsCnt = gha_pkg::CNT_W'(gha_pkg::SLOTS);

  logic en;
  logic in_acc;
  logic cfg_acc;

  logic [gha_pkg::CNT_W-1:0] active_q, active_d;
  logic [gha_pkg::CNT_W-1:0] fresh_q, fresh_d;
  logic [gha_pkg::CNT_W-1:0] count_q, count_d;
  logic [gha_pkg::IDX_W-1:0] head_q, head_d;
  logic [gha_pkg::IDX_W-1:0] tail;

  logic [gha_pkg::IDX_W-1:0] in_idx;
  logic [gha_pkg::GEN_W-1:0] in_gen;
  logic                      in_range;
  logic                      push;
  logic                      pop;
  gha_pkg::item_t            in_item;

  logic [gha_pkg::IDX_W-1:0] q_mem [gha_pkg::SLOTS];
  logic [gha_pkg::IDX_W-1:0] q_rd_q;

  logic                      s1_vld_q, s2_vld_q, out_vld_q;
  gha_pkg::item_t            s1_q, s2_q, s2_d;
  logic [gha_pkg::IDX_W-1:0] s1_slot;

  logic [gha_pkg::GEN_W-1:0] cur_gen;
  gha_pkg::gen_wr_t          gen_wr;

  logic [gha_pkg::IDX_W-1:0] res_idx, out_idx_q;
  logic [gha_pkg::GEN_W-1:0] res_gen, out_gen_q;
  gha_pkg::status_e          res_st, out_st_q;

  // Handshakes: the whole pipe moves when the output register can load.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i;

  assign in_idx   = s_axis_tdata[7:0];
  assign in_gen   = s_axis_tdata[15:8];
  assign in_range = {1'b0, in_idx} < active_q;
  assign tail     = head_q + count_q[gha_pkg::IDX_W-1:0];

  // Decode the item against the queue state and settle the bookkeeping.
  always_comb begin
    in_item.act    = gha_pkg::ACT_ERR;
    in_item.slot   = in_idx;
    in_item.gen    = in_gen;
    in_item.status = gha_pkg::ST_RANGE;
    push           = 1'b0;
    pop            = 1'b0;
    case (gha_pkg::func_e'(s_axis_tuser))
      gha_pkg::FUNC_ALLOC: begin
        if (fresh_q < active_q) begin
          in_item.act    = gha_pkg::ACT_ALLOC_FRESH;
          in_item.slot   = fresh_q[gha_pkg::IDX_W-1:0];
          in_item.status = gha_pkg::ST_OK;
        end else if (count_q != '0) begin
          in_item.act    = gha_pkg::ACT_ALLOC_QUEUE;
          in_item.status = gha_pkg::ST_OK;
          pop            = 1'b1;
        end else begin
          in_item.status = gha_pkg::ST_EXHAUSTED;
        end
      end
      gha_pkg::FUNC_RELEASE: begin
        if (!in_range) begin
          in_item.status = gha_pkg::ST_RANGE;
        end else if (count_q == SlotsCnt) begin
          in_item.status = gha_pkg::ST_FULL;
        end else begin
          in_item.act    = gha_pkg::ACT_RELEASE;
          in_item.status = gha_pkg::ST_OK;
          push           = 1'b1;
        end
      end
      gha_pkg::FUNC_LOOKUP: begin
        if (in_range) begin
          in_item.act    = gha_pkg::ACT_LOOKUP;
          in_item.status = gha_pkg::ST_OK;
        end
      end
      default: begin
        in_item.status = gha_pkg::ST_RANGE;
      end
    endcase
  end

  // Next values of the pool registers.
  always_comb begin
    active_d = active_q;
    fresh_d  = fresh_q;
    count_d  = count_q;
    head_d   = head_q;
    if (cfg_acc) begin
      active_d = (cfg_data_i > SlotsCnt) ? SlotsCnt : cfg_data_i;
      fresh_d  = '0;
      count_d  = '0;
      head_d   = '0;
    end else if (in_acc) begin
      if (in_item.act == gha_pkg::ACT_ALLOC_FRESH) begin
        fresh_d = fresh_q + 1'b1;
      end
      if (pop) begin
        head_d  = head_q + 1'b1;
        count_d = count_q - 1'b1;
      end
      if (push) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= SlotsCnt;
      fresh_q  <= '0;
      count_q  <= '0;
      head_q   <= '0;
    end else begin
      active_q <= active_d;
      fresh_q  <= fresh_d;
      count_q  <= count_d;
      head_q   <= head_d;
    end
  end

  // Free queue memory: push at the tail, pop read at the head.
  always_ff @(posedge clk_i) begin
    if (in_acc && push) begin
      q_mem[tail] <= in_idx;
    end
    if (in_acc && pop) begin
      q_rd_q <= q_mem[head_q];
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= s_axis_tvalid;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  // Stage one resolves the slot of a queue pop and reads its generation.
  assign s1_slot = (s1_q.act == gha_pkg::ACT_ALLOC_QUEUE) ? q_rd_q : s1_q.slot;

  always_comb begin
    s2_d      = s1_q;
    s2_d.slot = s1_slot;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= in_item;
      s2_q <= s2_d;
    end
  end

  // Stage two writes back the bumped generation of a release.
  assign gen_wr.valid = en && s2_vld_q && (s2_q.act == gha_pkg::ACT_RELEASE);
  assign gen_wr.addr  = s2_q.slot;
  assign gen_wr.gen   = cur_gen + 1'b1;

  gha_gen_table u_gen_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .clear_i   (cfg_acc),
    .rd_addr_i (s1_slot),
    .wr_i      (gen_wr),
    .cur_gen_o (cur_gen)
  );

  // Result fields of stage two.
  always_comb begin
    res_idx = s2_q.slot;
    res_gen = cur_gen;
    res_st  = gha_pkg::ST_OK;
    case (s2_q.act)
      gha_pkg::ACT_ALLOC_FRESH, gha_pkg::ACT_ALLOC_QUEUE: begin
        res_st = gha_pkg::ST_OK;
      end
      gha_pkg::ACT_RELEASE: begin
        res_gen = gen_wr.gen;
      end
      gha_pkg::ACT_LOOKUP: begin
        res_st = (cur_gen == s2_q.gen) ? gha_pkg::ST_OK : gha_pkg::ST_STALE;
      end
      default: begin
        res_idx = '0;
        res_gen = '0;
        res_st  = s2_q.status;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_idx_q <= res_idx;
      out_gen_q <= res_gen;
      out_st_q  <= res_st;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_gen_q, out_idx_q};
  assign m_axis_tuser  = out_st_q;

  // The fresh counter never runs past the pool size.
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= active_q)
    else $error("fresh counter beyond active slots");

  // An accepted release that passes its checks grows the queue by one.
  a_release_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_acc && (in_item.act == gha_pkg::ACT_RELEASE))
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("release did not queue the slot");

  // An exhausted pool reports an empty handle.
  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == gha_pkg::ST_EXHAUSTED)) |-> (m_axis_tdata == '0))
    else $error("exhausted result carries a handle");

  // The queue never holds more entries than slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SlotsCnt)
    else $error("free queue count overflow");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Drives allocate, release and lookup items into the allocator, predicts each
// result with a local model of the pool, and compares the results in order.
// Runs a directed part, a queue-full and generation-wrap part, random traffic
// under several idling mixes and pool sizes, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;

  // Result of one item as the block reports it.
  typedef struct packed {
    logic [gha_pkg::IDX_W-1:0] idx;
    logic [gha_pkg::GEN_W-1:0] gen;
    gha_pkg::status_e          status;
  } handle_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] slot_index, [15:8] generation
  logic [1:0]  s_axis_tuser = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] out_index, [15:8] out_generation
  logic [2:0]  m_axis_tuser;        // [2:0] status

  // Local copy of the pool state.
  logic [gha_pkg::IDX_W-1:0] pool_fifo [gha_pkg::SLOTS];
  logic [gha_pkg::GEN_W-1:0] slot_gen [gha_pkg::SLOTS];
  int                        pool_head;
  int                        pool_count;
  int                        next_fresh;
  int                        slot_limit;

  handle_res_t pending_q [$];
  handle_res_t live_q [$];
  int          errors;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          hold_req;
  int          hold_left;
  int          quiet_cycles;

  generational_handle_allocator_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Empty the pool and set its size; values above the slot count are clamped.
  function automatic void clear_pool(int unsigned size);
    slot_limit = (size > gha_pkg::SLOTS) ? int'(gha_pkg::SLOTS) : int'(size);
    pool_head  = 0;
    pool_count = 0;
    next_fresh = 0;
    pool_fifo  = '{default: '0};
    slot_gen   = '{default: '0};
  endfunction

  // Work out the result of one item and update the local pool state.
  function automatic handle_res_t predict_handle(gha_pkg::func_e f,
                                                 logic [gha_pkg::IDX_W-1:0] idx,
                                                 logic [gha_pkg::GEN_W-1:0] gen);
    handle_res_t r;
    int          s;
    int          t;
    r = '{idx: '0, gen: '0, status: gha_pkg::ST_OK};
    case (f)
      gha_pkg::FUNC_ALLOC: begin
        s = -1;
        if (next_fresh < slot_limit) begin
          s = next_fresh;
          next_fresh++;
        end else if (pool_count > 0) begin
          s = int'(pool_fifo[pool_head[gha_pkg::IDX_W-1:0]]);
          pool_head = (pool_head + 1) % gha_pkg::SLOTS;
          pool_count--;
        end
        if (s < 0) begin
          r.status = gha_pkg::ST_EXHAUSTED;
        end else begin
          r.idx = s[gha_pkg::IDX_W-1:0];
          r.gen = slot_gen[s[gha_pkg::IDX_W-1:0]];
        end
      end
      gha_pkg::FUNC_RELEASE: begin
        if (idx >= slot_limit) begin
          r.status = gha_pkg::ST_RANGE;
        end else if (pool_count >= gha_pkg::SLOTS) begin
          r.status = gha_pkg::ST_FULL;
        end else begin
          slot_gen[idx] = slot_gen[idx] + 1'b1;
          t = (pool_head + pool_count) % gha_pkg::SLOTS;
          pool_fifo[t[gha_pkg::IDX_W-1:0]] = idx;
          pool_count++;
          r.idx = idx;
          r.gen = slot_gen[idx];
        end
      end
      gha_pkg::FUNC_LOOKUP: begin
        if (idx >= slot_limit) begin
          r.status = gha_pkg::ST_RANGE;
        end else begin
          r.idx    = idx;
          r.gen    = slot_gen[idx];
          r.status = (slot_gen[idx] != gen) ? gha_pkg::ST_STALE : gha_pkg::ST_OK;
        end
      end
      default: begin
        r.status = gha_pkg::ST_RANGE;
      end
    endcase
    return r;
  endfunction

  // Offer one item after a random idle gap and record its expected result.
  task automatic send_item(input gha_pkg::func_e f, input logic [gha_pkg::IDX_W-1:0] idx,
                           input logic [gha_pkg::GEN_W-1:0] gen, output handle_res_t res);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {gen, idx};
    s_axis_tuser  <= f;
    do @(posedge clk); while (!s_axis_tready);
    res = predict_handle(f, idx, gen);
    pending_q.push_back(res);
  endtask

  // Stop offering items and wait until every result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write active_slots; only called while the block is idle.
  task automatic write_active_slots(input int unsigned size);
    cfg_valid <= 1'b1;
    cfg_data  <= size[8:0];
    do @(posedge clk); while (!cfg_ready);
    clear_pool(size);
    cfg_valid <= 1'b0;
    live_q.delete();
    @(posedge clk);
  endtask

  // One random item: mostly handles the pool handed out, the rest noise.
  task automatic send_random_op();
    handle_res_t res;
    handle_res_t h;
    int          k;
    int          kind;
    logic [7:0]  idx;
    logic [7:0]  gen;
    if ($urandom_range(99) < 70) begin
      kind = $urandom_range(2);
      if (kind == 1 && live_q.size() > 0) begin
        k = $urandom_range(live_q.size() - 1);
        h = live_q[k];
        live_q.delete(k);
        send_item(gha_pkg::FUNC_RELEASE, h.idx, 8'($urandom()), res);
      end else if (kind == 2 && live_q.size() > 0) begin
        k = $urandom_range(live_q.size() - 1);
        h = live_q[k];
        gen = ($urandom_range(3) == 0) ? h.gen + 8'd1 : h.gen;
        send_item(gha_pkg::FUNC_LOOKUP, h.idx, gen, res);
      end else begin
        send_item(gha_pkg::FUNC_ALLOC, 8'($urandom()), 8'($urandom()), res);
        if (res.status == gha_pkg::ST_OK) live_q.push_back(res);
      end
    end else begin
      idx = ($urandom_range(1) == 0) ? 8'($urandom_range(slot_limit - 1)) : 8'($urandom());
      send_item(gha_pkg::func_e'($urandom_range(3)), idx, 8'($urandom()), res);
    end
  endtask

  // Edge cases straight after reset, then with a one-slot pool.
  task automatic test_directed();
    handle_res_t res;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_item(gha_pkg::FUNC_ALLOC, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_ALLOC, 8'hff, 8'hff, res);
    send_item(gha_pkg::FUNC_LOOKUP, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_LOOKUP, 8'h00, 8'hff, res);
    send_item(gha_pkg::FUNC_RELEASE, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_LOOKUP, 8'h00, 8'h01, res);
    send_item(gha_pkg::FUNC_RELEASE, 8'hff, 8'hff, res);
    send_item(gha_pkg::FUNC_LOOKUP, 8'hff, 8'h00, res);
    send_item(gha_pkg::FUNC_RSVD, 8'hff, 8'hff, res);
    send_item(gha_pkg::FUNC_ALLOC, 8'h00, 8'h00, res);
    wait_drained();
    write_active_slots(1);
    send_item(gha_pkg::FUNC_ALLOC, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_ALLOC, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_RELEASE, 8'h01, 8'h00, res);
    send_item(gha_pkg::FUNC_LOOKUP, 8'hff, 8'h00, res);
    send_item(gha_pkg::FUNC_RELEASE, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_ALLOC, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_LOOKUP, 8'h00, 8'h01, res);
    // Releasing a slot that is not held is not detected.
    send_item(gha_pkg::FUNC_RELEASE, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_RELEASE, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_ALLOC, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_ALLOC, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_ALLOC, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_RSVD, 8'h00, 8'h00, res);
    wait_drained();
  endtask

  // Fill the free queue with releases of one slot, which also wraps its generation.
  task automatic test_queue_full();
    handle_res_t res;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_active_slots(300);
    repeat (gha_pkg::SLOTS) send_item(gha_pkg::FUNC_RELEASE, 8'h00, 8'($urandom()), res);
    send_item(gha_pkg::FUNC_RELEASE, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_RELEASE, 8'hff, 8'hff, res);
    send_item(gha_pkg::FUNC_LOOKUP, 8'h00, 8'h00, res);
    send_item(gha_pkg::FUNC_LOOKUP, 8'h00, 8'h01, res);
    repeat (4) send_item(gha_pkg::FUNC_ALLOC, 8'($urandom()), 8'($urandom()), res);
    wait_drained();
  endtask

  // Random traffic with a given pool size and idling mix.
  task automatic test_random_traffic(input int count, input int src_pct,
                                     input int sink_pct, input int unsigned size);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    write_active_slots(size);
    repeat (count) send_random_op();
    wait_drained();
  endtask

  // Hold the output off for a long stretch while items keep coming.
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_active_slots(200);
    hold_req = HOLD_CYCLES;
    repeat (60) send_random_op();
    wait_drained();
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    handle_res_t want;
    handle_res_t got;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got.idx    = m_axis_tdata[7:0];
      got.gen    = m_axis_tdata[15:8];
      got.status = gha_pkg::status_e'(m_axis_tuser);
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected, got idx %0d gen %0d status %0d",
                 $time, got.idx, got.gen, got.status);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.idx !== want.idx || got.gen !== want.gen ||
            got.status !== want.status) begin
          $display("%0t: mismatch, expected idx %0d gen %0d status %0d,",
                   $time, want.idx, want.gen, want.status,
                   " got idx %0d gen %0d status %0d", got.idx, got.gen, got.status);
          errors++;
        end
      end
    end
  end

  // Drive the output ready, with a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // End the run if no handshake happens for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    errors         = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    clear_pool(gha_pkg::SLOTS);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_queue_full();
    test_random_traffic(250, 0, 0, gha_pkg::SLOTS);
    test_random_traffic(200, 61, 0, 8);
    test_random_traffic(150, 0, 61, 1);
    test_random_traffic(250, 38, 38, $urandom_range(64, 2));
    test_backpressure();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### generational_handle_allocator_top.f
design/gha_pkg.sv
design/gha_gen_table.sv
design/generational_handle_allocator_top.sv
tb/tb.sv
